>>> hw/rtl/vlf_pkg.sv
// Shared types and constants for the vehicle light frame controller.
// No dependencies; used by the top level and by vlf_shade.
package vlf_pkg;

  localparam int MAX_PIXELS_DEF = 64;

  localparam logic [6:0]  PIXEL_COUNT_RST  = 7'd16;
  localparam logic [15:0] BLINK_PERIOD_RST = 16'd4;

  localparam logic [7:0] WHITE_LVL  = 8'd100;
  localparam logic [7:0] YELLOW_LVL = 8'd100;
  localparam logic [7:0] TAIL_LVL   = 8'd50;
  localparam logic [7:0] BRAKE_LVL  = 8'd255;
  localparam logic [7:0] PULSE_STEP = 8'd5;
  localparam logic [7:0] PULSE_TOP  = 8'd255;
  localparam logic [7:0] PULSE_BOT  = 8'd0;

  typedef enum logic [3:0] {
    CMD_DEAD       = 4'd0,
    CMD_ALIVE      = 4'd1,
    CMD_NONE       = 4'd2,
    CMD_NEUTRAL    = 4'd3,
    CMD_POWER      = 4'd4,
    CMD_BRAKE      = 4'd5,
    CMD_LEFT       = 4'd6,
    CMD_RIGHT      = 4'd7,
    CMD_TURN_OFF   = 4'd8,
    CMD_LIGHTS_ON  = 4'd9,
    CMD_LIGHTS_OFF = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_PIXEL_COUNT  = 3'd0,
    CFG_FRONT_SPAN   = 3'd1,
    CFG_BACK_SPAN    = 3'd2,
    CFG_LEFT_SPAN    = 3'd3,
    CFG_RIGHT_SPAN   = 3'd4,
    CFG_BLINK_PERIOD = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_t;

  typedef enum logic [1:0] {
    FK_OFF    = 2'd0,
    FK_DEAD   = 2'd1,
    FK_NORMAL = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic       mode;
    logic [3:0] command_code;
  } in_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_t;

  typedef struct packed {
    frame_kind_t kind;
    logic        brake;
    logic        left_on;
    logic        right_on;
    logic        blink_phase;
    logic [7:0]  level;
    logic [15:0] front_span;
    logic [15:0] back_span;
    logic [15:0] left_span;
    logic [15:0] right_span;
  } shade_ctl_t;

endpackage

>>> hw/rtl/vehicle_light_frame_controller_core.sv
// Vehicle light frame controller, top level.
// Depends on vlf_pkg, vlf_ram (frame store) and vlf_shade (pixel colour).
//
// Usage:
// - in_ channel (valid/stall): one beat is a command (mode 0) or a frame
//   tick (mode 1). A command yields no beat.
// - A frame tick redraws the frame store and sends n = min(pixel_count,
//   MAX_PIXELS) beats on the out_ channel, index 0 first, last_pixel set on
//   the final one. A tick with n = 0 sends nothing.
// - The frame store is walked by one pixel sequencer: one RAM read and one
//   shared span-compare/colour unit per pixel, one pixel per cycle while
//   out_stall is low. Each pixel goes through the RAM read, the pixel stage
//   and the output register; in_stall stays high until the last pixel
//   moves from the pixel stage into the output register.
// - out_stall holds the output register and pauses the walk; nothing is
//   lost. The next item is taken while the last pixel still waits.
// - cfg_ channel (valid/ready, always ready): register index and data;
//   write only while the block is idle.
// - rst_n (synchronous) restores register defaults, sets lights on, clears
//   other flags and marks every frame pixel black at once; no clearing pass.
module vehicle_light_frame_controller_core #(
  parameter int MAX_PIXELS = vlf_pkg::MAX_PIXELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vlf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output vlf_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int IW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam logic [8:0] MAX9 = 9'(MAX_PIXELS);

  // configuration
  logic [6:0]  pixel_count_r;
  logic [15:0] front_span_r, back_span_r, left_span_r, right_span_r;
  logic [15:0] blink_period_r;

  // vehicle state
  logic        lights_r, lights_nxt;
  logic        dead_r, dead_nxt;
  logic        brake_r, brake_nxt;
  logic        left_r, left_nxt;
  logic        right_r, right_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [7:0]  pulse_r, pulse_nxt;
  logic        falling_r, falling_nxt;

  // sequencer
  vlf_pkg::seq_state_t  state_r, state_nxt;
  vlf_pkg::frame_kind_t kind_r, kind_nxt;
  logic [7:0]            level_r, level_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                  s1_v_r, s1_v_nxt;
  logic [CW-1:0]         s1_idx_r, s1_idx_nxt;
  logic                  vld_rd_r;
  logic [MAX_PIXELS-1:0] vld_r, vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  vlf_pkg::out_t         out_r, out_nxt;

  logic          in_acc;
  logic          adv;
  logic          s1_go;
  logic          can_rd;
  logic          last;
  logic [8:0]    pc9;
  logic [CW-1:0] n_act;
  logic [15:0]   ticks_inc;
  logic [15:0]   period;
  logic [7:0]    pulse_mv;
  logic [7:0]    idx8;
  logic [23:0]   ram_rdata;
  logic [23:0]   old_rgb;
  logic [23:0]   new_rgb;
  vlf_pkg::shade_ctl_t shade_ctl;

  assign in_stall  = (state_r != vlf_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pc9   = {2'b00, pixel_count_r};
  assign n_act = (pc9 > MAX9) ? CW'(MAX9) : CW'(pc9);

  assign ticks_inc = ticks_r + 16'd1;
  assign period    = (blink_period_r == 16'd0) ? 16'd1 : blink_period_r;
  assign pulse_mv  = falling_r ? (pulse_r - vlf_pkg::PULSE_STEP)
                               : (pulse_r + vlf_pkg::PULSE_STEP);

  assign adv    = !out_valid_r || !out_stall;
  assign s1_go  = s1_v_r && adv;
  assign can_rd = (state_r == vlf_pkg::ST_RUN) && (rd_cnt_r != n_r) && (!s1_v_r || adv);
  assign last   = ((s1_idx_r + CW'(1)) == n_r);
  assign idx8   = 8'(s1_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r  <= vlf_pkg::PIXEL_COUNT_RST;
      front_span_r   <= '0;
      back_span_r    <= '0;
      left_span_r    <= '0;
      right_span_r   <= '0;
      blink_period_r <= vlf_pkg::BLINK_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (vlf_pkg::cfg_reg_t'(cfg_index))
        vlf_pkg::CFG_PIXEL_COUNT:  pixel_count_r  <= cfg_data[6:0];
        vlf_pkg::CFG_FRONT_SPAN:   front_span_r   <= cfg_data;
        vlf_pkg::CFG_BACK_SPAN:    back_span_r    <= cfg_data;
        vlf_pkg::CFG_LEFT_SPAN:    left_span_r    <= cfg_data;
        vlf_pkg::CFG_RIGHT_SPAN:   right_span_r   <= cfg_data;
        vlf_pkg::CFG_BLINK_PERIOD: blink_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lights_nxt    = lights_r;
    dead_nxt      = dead_r;
    brake_nxt     = brake_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    phase_nxt     = phase_r;
    ticks_nxt     = ticks_r;
    pulse_nxt     = pulse_r;
    falling_nxt   = falling_r;
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    level_nxt     = level_r;
    n_nxt         = n_r;
    rd_cnt_nxt    = rd_cnt_r;
    s1_v_nxt      = s1_v_r;
    s1_idx_nxt    = s1_idx_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    case (state_r)
      vlf_pkg::ST_IDLE: begin
        if (in_acc && !in_data.mode) begin
          case (vlf_pkg::cmd_t'(in_data.command_code))
            vlf_pkg::CMD_DEAD:       dead_nxt = 1'b1;
            vlf_pkg::CMD_ALIVE:      dead_nxt = 1'b0;
            vlf_pkg::CMD_LIGHTS_ON:  lights_nxt = 1'b1;
            vlf_pkg::CMD_LIGHTS_OFF: lights_nxt = 1'b0;
            vlf_pkg::CMD_NONE: begin
              if (!dead_r) begin
                brake_nxt = 1'b0;
                left_nxt  = 1'b0;
                right_nxt = 1'b0;
              end
            end
            vlf_pkg::CMD_NEUTRAL, vlf_pkg::CMD_POWER: begin
              if (!dead_r) brake_nxt = 1'b0;
            end
            vlf_pkg::CMD_BRAKE: begin
              if (!dead_r) brake_nxt = 1'b1;
            end
            vlf_pkg::CMD_LEFT, vlf_pkg::CMD_RIGHT: begin
              if (!dead_r) begin
                ticks_nxt = '0;
                phase_nxt = 1'b1;
                left_nxt  = (in_data.command_code == vlf_pkg::CMD_LEFT);
                right_nxt = (in_data.command_code == vlf_pkg::CMD_RIGHT);
              end
            end
            vlf_pkg::CMD_TURN_OFF: begin
              if (!dead_r) begin
                left_nxt  = 1'b0;
                right_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end else if (in_acc) begin
          n_nxt      = n_act;
          rd_cnt_nxt = '0;
          s1_v_nxt   = 1'b0;
          if (!lights_r) begin
            kind_nxt = vlf_pkg::FK_OFF;
            vld_nxt  = '0;
          end else if (dead_r) begin
            kind_nxt  = vlf_pkg::FK_DEAD;
            level_nxt = pulse_r;
            if (n_act != '0) begin
              pulse_nxt = pulse_mv;
              if (pulse_mv == vlf_pkg::PULSE_TOP || pulse_mv == vlf_pkg::PULSE_BOT) begin
                falling_nxt = !falling_r;
              end
            end
          end else begin
            kind_nxt = vlf_pkg::FK_NORMAL;
            if (ticks_inc >= period) begin
              ticks_nxt = '0;
              phase_nxt = !phase_r;
            end else begin
              ticks_nxt = ticks_inc;
            end
          end
          if (n_act != '0) state_nxt = vlf_pkg::ST_RUN;
        end
      end
      vlf_pkg::ST_RUN: begin
        if (can_rd) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          s1_idx_nxt = rd_cnt_r;
          s1_v_nxt   = 1'b1;
        end else if (s1_go) begin
          s1_v_nxt = 1'b0;
        end
        if (rd_cnt_r == n_r && (!s1_v_r || s1_go)) state_nxt = vlf_pkg::ST_IDLE;
      end
      default: state_nxt = vlf_pkg::ST_IDLE;
    endcase

    if (s1_go) begin
      vld_nxt[s1_idx_r[IW-1:0]] = 1'b1;
      out_valid_nxt             = 1'b1;
      out_nxt.pixel_index       = idx8[5:0];
      out_nxt.red               = new_rgb[23:16];
      out_nxt.green             = new_rgb[15:8];
      out_nxt.blue              = new_rgb[7:0];
      out_nxt.last_pixel        = last;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lights_r    <= 1'b1;
      dead_r      <= 1'b0;
      brake_r     <= 1'b0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      phase_r     <= 1'b0;
      ticks_r     <= '0;
      pulse_r     <= '0;
      falling_r   <= 1'b0;
      state_r     <= vlf_pkg::ST_IDLE;
      rd_cnt_r    <= '0;
      n_r         <= '0;
      s1_v_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lights_r    <= lights_nxt;
      dead_r      <= dead_nxt;
      brake_r     <= brake_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      phase_r     <= phase_nxt;
      ticks_r     <= ticks_nxt;
      pulse_r     <= pulse_nxt;
      falling_r   <= falling_nxt;
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      n_r         <= n_nxt;
      s1_v_r      <= s1_v_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    level_r  <= level_nxt;
    s1_idx_r <= s1_idx_nxt;
    out_r    <= out_nxt;
    if (can_rd) vld_rd_r <= vld_r[rd_cnt_r[IW-1:0]];
  end

  vlf_ram #(
    .WIDTH(24),
    .DEPTH(MAX_PIXELS)
  ) u_frame (
    .clk  (clk),
    .we   (s1_go),
    .waddr(s1_idx_r[IW-1:0]),
    .wdata(new_rgb),
    .re   (can_rd),
    .raddr(rd_cnt_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign old_rgb = vld_rd_r ? ram_rdata : '0;

  assign shade_ctl.kind        = kind_r;
  assign shade_ctl.brake       = brake_r;
  assign shade_ctl.left_on     = left_r;
  assign shade_ctl.right_on    = right_r;
  assign shade_ctl.blink_phase = phase_r;
  assign shade_ctl.level       = level_r;
  assign shade_ctl.front_span  = front_span_r;
  assign shade_ctl.back_span   = back_span_r;
  assign shade_ctl.left_span   = left_span_r;
  assign shade_ctl.right_span  = right_span_r;

  vlf_shade u_shade (
    .ctl    (shade_ctl),
    .idx    (idx8),
    .old_rgb(old_rgb),
    .new_rgb(new_rgb)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vlf_pkg::ST_IDLE) |-> !s1_v_r)
    else $error("pixel stage busy while sequencer idle");

  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vlf_pkg::ST_RUN) |-> (rd_cnt_r <= n_r))
    else $error("frame read count beyond pixel count");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> (s1_idx_r < n_r))
    else $error("frame write beyond pixel count");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && last) |=> (state_r == vlf_pkg::ST_IDLE))
    else $error("sequencer still running after last pixel");

endmodule

>>> hw/rtl/vlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while re is low. No dependencies.
module vlf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/vlf_shade.sv
// Per-pixel colour for one frame: span tests, turn blink, dead pulse, all off.
// Depends on vlf_pkg.
module vlf_shade (
  input  vlf_pkg::shade_ctl_t ctl,
  input  logic [7:0]          idx,
  input  logic [23:0]         old_rgb,
  output logic [23:0]         new_rgb
);

  function automatic logic in_span(input logic [15:0] span, input logic [7:0] i);
    in_span = (i >= span[7:0]) && (i <= span[15:8]);
  endfunction

  logic [23:0] yellow;
  logic [23:0] white;
  logic [23:0] tail;

  assign yellow = {vlf_pkg::YELLOW_LVL, vlf_pkg::YELLOW_LVL, 8'h00};
  assign white  = {vlf_pkg::WHITE_LVL, vlf_pkg::WHITE_LVL, vlf_pkg::WHITE_LVL};
  assign tail   = {(ctl.brake ? vlf_pkg::BRAKE_LVL : vlf_pkg::TAIL_LVL), 16'h0000};

  always_comb begin
    new_rgb = old_rgb;
    case (ctl.kind)
      vlf_pkg::FK_OFF: begin
        new_rgb = '0;
      end
      vlf_pkg::FK_DEAD: begin
        new_rgb = {ctl.level, 16'h0000};
      end
      vlf_pkg::FK_NORMAL: begin
        if (in_span(ctl.front_span, idx)) new_rgb = white;
        if (in_span(ctl.back_span, idx)) new_rgb = tail;
        if (in_span(ctl.left_span, idx)) new_rgb = '0;
        if (in_span(ctl.right_span, idx)) new_rgb = '0;
        if (ctl.blink_phase) begin
          if (ctl.left_on) begin
            if (idx == ctl.front_span[7:0] || idx == ctl.back_span[15:8] ||
                in_span(ctl.left_span, idx)) new_rgb = yellow;
          end else if (ctl.right_on) begin
            if (idx == ctl.front_span[15:8] || idx == ctl.back_span[7:0] ||
                in_span(ctl.right_span, idx)) new_rgb = yellow;
          end
        end
      end
      default: begin
        new_rgb = '0;
      end
    endcase
  end

endmodule
